// File: rtl/core/bch3121_pkg.sv
// Types, constants and helper functions for the BCH(31,21) paging codec.
// Holds the generator, the Meggitt syndrome pattern list and the stage record.
// Depends on nothing; the codec top level imports it.
`timescale 1ns / 1ps
`default_nettype none

package bch3121_pkg;

  localparam int CW_W          = 32;
  localparam int DAT_W         = 21;
  localparam int SYN_W         = 10;
  localparam int N_STEPS       = 31;
  localparam int N_PAT         = 31;
  localparam int STEPS_PER_STG = 8;
  localparam int N_MEG_STG     = (N_STEPS + STEPS_PER_STG - 1) / STEPS_PER_STG;

  localparam logic [CW_W-1:0]  GEN_HIGH = 32'hED20_0000;
  localparam logic [10:0]      GEN_POLY = 11'h769;
  localparam logic [SYN_W-1:0] MSB_SYN  = 10'h3B4;

  localparam logic REQ_ENCODE = 1'b0;
  localparam logic REQ_DECODE = 1'b1;

  typedef logic [N_PAT-1:0][SYN_W-1:0] pat_arr_t;
  typedef logic [DAT_W-1:0][SYN_W-1:0] chk_col_arr_t;

  localparam pat_arr_t PAT_TAB = {
    10'h3B4, 10'h26E, 10'h359, 10'h076, 10'h255, 10'h0F0, 10'h216, 10'h365,
    10'h068, 10'h25A, 10'h343, 10'h07B, 10'h1E7, 10'h129, 10'h14E, 10'h2C9,
    10'h0BE, 10'h231, 10'h0C2, 10'h20F, 10'h0DD, 10'h1B4, 10'h2B4, 10'h334,
    10'h3F4, 10'h394, 10'h3A4, 10'h3BC, 10'h3B0, 10'h3B6, 10'h3B5
  };

  // One record of the correction pipeline.
  typedef struct packed {
    logic              vld;
    logic              req;
    logic              zero;
    logic [CW_W-1:0]   w;
    logic [CW_W-2:0]   fx;
    logic [SYN_W-1:0]  syn;
  } meg_stg_t;

  // Check bits contributed by each data bit alone. Evaluated at elaboration only.
  function automatic chk_col_arr_t chk_cols();
    chk_col_arr_t   c;
    logic [CW_W-1:0] rem;
    for (int j = 0; j < DAT_W; j++) begin
      rem = 32'h1 << (CW_W - DAT_W + j);
      for (int i = 0; i < DAT_W; i++) begin
        if (rem[CW_W-1]) begin
          rem = rem ^ GEN_HIGH;
        end
        rem = rem << 1;
      end
      c[j] = rem[CW_W-1:CW_W-SYN_W];
    end
    return c;
  endfunction

  localparam chk_col_arr_t CHK_COL = chk_cols();

  // The check bits are linear in the data, so they are an XOR of columns.
  function automatic logic [SYN_W-1:0] syn_check(input logic [DAT_W-1:0] data);
    logic [SYN_W-1:0] acc;
    acc = '0;
    for (int j = 0; j < DAT_W; j++) begin
      if (data[j]) begin
        acc = acc ^ CHK_COL[j];
      end
    end
    return acc;
  endfunction

  function automatic logic pat_hit(input logic [SYN_W-1:0] s);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < N_PAT; i++) begin
      if (PAT_TAB[i] == s) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

  function automatic logic [SYN_W-1:0] syn_shift(input logic [SYN_W-1:0] s);
    logic [SYN_W-1:0] sh;
    sh = {s[SYN_W-2:0], 1'b0};
    if (s[SYN_W-1]) begin
      sh = sh ^ GEN_POLY[SYN_W-1:0];
    end
    return sh;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/bch_31_21_codec_with_parity.sv
// Top level of the BCH(31,21) paging codec with even parity.
// Depends on bch3121_pkg for the generator, the pattern list and the stage record.
//
// Usage: present req_type and code_word with start high; the word is taken at
// the rising edge where start is high and busy is low. busy is high only while
// rst is held, so a new word can be taken on every cycle.
// req_type encode keeps bits 31..11, fills the ten check bits and sets bit 0 for
// even parity. req_type decode computes the syndrome; a zero syndrome returns the
// word unchanged, otherwise a Meggitt corrector walks bits 31..1 and returns the
// corrected word with bit 0 cleared, or the input word with status high when
// the errors cannot be corrected.
// Timing: done is high for one cycle per result; each word passes the input
// register, syndrome register, four correction stages and output register.
// Throughput: one word per cycle. The 31 correction steps are split over four
// register stages of at most eight steps each, which sets the pipeline depth.
// Reset: rst clears all valid bits; words in flight are dropped.
// The receiver cannot stall: every result must be taken in its done cycle.
`timescale 1ns / 1ps
`default_nettype none

module bch_31_21_codec_with_parity
  import bch3121_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output      logic             busy,
  input  wire logic             req_type,
  input  wire logic [CW_W-1:0]  code_word,
  output      logic             done,
  output      logic [CW_W-1:0]  word_out,
  output      logic             status
);

  logic             in_vld;
  logic             in_req;
  logic [CW_W-1:0]  in_w;

  logic [SYN_W-1:0] chk;
  logic [CW_W-1:0]  enc;
  logic [SYN_W-1:0] syn;
  meg_stg_t         syn_next;

  meg_stg_t         stg [N_MEG_STG+1];
  meg_stg_t         stg_next [N_MEG_STG];
  meg_stg_t         fin;

  logic             out_req;
  logic             out_zero;

  assign busy = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else begin
      in_vld <= start && !busy;
    end
    in_req <= req_type;
    in_w   <= code_word;
  end

  // Syndrome stage: re-encode the data bits and compare check bits.
  always_comb begin
    chk = syn_check(in_w[CW_W-1:CW_W-DAT_W]);
    enc = {in_w[CW_W-1:CW_W-DAT_W], chk, ^{in_w[CW_W-1:CW_W-DAT_W], chk}};
    syn = chk ^ in_w[SYN_W:1];
    syn_next.vld = in_vld;
    syn_next.req = in_req;
    syn_next.fx  = in_w[CW_W-1:1];
    syn_next.syn = syn;
    if (in_req == REQ_ENCODE) begin
      syn_next.w    = enc;
      syn_next.zero = 1'b1;
    end else begin
      syn_next.w    = in_w;
      syn_next.zero = (syn == '0);
    end
  end

  // Each correction stage runs up to STEPS_PER_STG Meggitt steps, MSB first.
  always_comb begin
    for (int s = 0; s < N_MEG_STG; s++) begin
      stg_next[s] = stg[s];
      for (int k = 0; k < STEPS_PER_STG; k++) begin
        if (s * STEPS_PER_STG + k < N_STEPS) begin
          if (pat_hit(stg_next[s].syn)) begin
            stg_next[s].syn = stg_next[s].syn ^ MSB_SYN;
            stg_next[s].fx[N_STEPS-1-(s*STEPS_PER_STG+k)] =
              ~stg_next[s].fx[N_STEPS-1-(s*STEPS_PER_STG+k)];
          end
          stg_next[s].syn = syn_shift(stg_next[s].syn);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s <= N_MEG_STG; s++) begin
        stg[s].vld <= 1'b0;
      end
    end else begin
      stg[0] <= syn_next;
      for (int s = 0; s < N_MEG_STG; s++) begin
        stg[s+1] <= stg_next[s];
      end
    end
  end

  assign fin = stg[N_MEG_STG];

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= fin.vld;
    end
    out_req  <= fin.req;
    out_zero <= fin.zero;
    if (fin.zero) begin
      word_out <= fin.w;
      status   <= 1'b0;
    end else if (fin.syn != '0) begin
      word_out <= fin.w;
      status   <= 1'b1;
    end else begin
      word_out <= {fin.fx, 1'b0};
      status   <= 1'b0;
    end
  end

  // Every accepted word completes with done high.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##7 done)
    else $error("accepted word did not complete after seven cycles");

  // An encoded word always has even parity and never reports failure.
  a_enc_parity: assert property (@(posedge clk) disable iff (rst)
    done && out_req == REQ_ENCODE |-> (^word_out) == 1'b0 && !status)
    else $error("encoded word has odd parity or nonzero status");

  // Only a decode can be uncorrectable.
  a_status_decode: assert property (@(posedge clk) disable iff (rst)
    done && status |-> out_req == REQ_DECODE && !out_zero)
    else $error("uncorrectable flag on a word that was not corrected");

  // A word that went through correction successfully has bit 0 cleared.
  a_fix_bit0: assert property (@(posedge clk) disable iff (rst)
    done && out_req == REQ_DECODE && !out_zero && !status |-> !word_out[0])
    else $error("corrected word has bit 0 set");

endmodule

`default_nettype wire
